/* hw/rtl/qmn_pkg.sv */
package qmn_pkg;

    localparam int QB = 31;
    localparam int SW = 64;
    localparam int RW = 32;
    localparam int ROOT_STEPS = 32;

    typedef struct packed {
        logic [3:0][QB-1:0] q;
        logic [3:0]         neg;
        logic               zero;
    } side_t;

endpackage

/* hw/rtl/qmn_ifs.sv */
interface qmn_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] b_w;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
    modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

interface qmn_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic signed [W-1:0] r_w;
    logic                zero_norm;

    modport source (output valid, r_x, r_y, r_z, r_w, zero_norm, input ready);
    modport sink (input valid, r_x, r_y, r_z, r_w, zero_norm, output ready);
endinterface

/* hw/rtl/quaternion_multiply_normalize.sv */
// Normalized Hamilton product of two fixed-point quaternions (14 fraction bits by
// default). One transaction is accepted every cycle while the output is not held
// off. Most of the pipeline is the 32-stage square root, which resolves one root
// bit per stage, and the four dividers, which resolve one quotient bit per stage.
// When the output is held off, the whole pipeline stalls and nothing is lost; a zero
// product gives zeros with zero_norm set.
module quaternion_multiply_normalize #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input logic   clk,
    input logic   rst_n,
    qmn_in_if.sink    operands,
    qmn_out_if.source result
);
    import qmn_pkg::*;

    localparam int W  = COMPONENT_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * W + 2;
    localparam int MW = 2 * W + 1;
    localparam int XW = (MW > QB) ? MW : QB;
    localparam int LW = $clog2(MW + 1);
    localparam int DW = RW + F + 1;
    localparam int CW = ((F + 1 > W) ? F + 1 : W) + 1;

    function automatic logic signed [PW-1:0] sx(input logic signed [2*W-1:0] v);
        return {{2{v[2*W-1]}}, v};
    endfunction

    logic adv;
    logic out_valid_reg;
    logic signed [W-1:0] r_reg [4];
    logic zero_reg;

    assign adv = !out_valid_reg || result.ready;
    assign operands.ready = adv;

    // Multiply stage.
    logic va_reg;
    logic signed [2*W-1:0] prod_reg [16];
    logic signed [2*W-1:0] prod_next [16];

    always_comb
    begin
        prod_next[0]  = operands.a_x * operands.b_w;
        prod_next[1]  = operands.a_y * operands.b_z;
        prod_next[2]  = operands.a_z * operands.b_y;
        prod_next[3]  = operands.a_w * operands.b_x;
        prod_next[4]  = operands.a_x * operands.b_z;
        prod_next[5]  = operands.a_y * operands.b_w;
        prod_next[6]  = operands.a_z * operands.b_x;
        prod_next[7]  = operands.a_w * operands.b_y;
        prod_next[8]  = operands.a_x * operands.b_y;
        prod_next[9]  = operands.a_y * operands.b_x;
        prod_next[10] = operands.a_z * operands.b_w;
        prod_next[11] = operands.a_w * operands.b_z;
        prod_next[12] = operands.a_x * operands.b_x;
        prod_next[13] = operands.a_y * operands.b_y;
        prod_next[14] = operands.a_z * operands.b_z;
        prod_next[15] = operands.a_w * operands.b_w;
    end

    // Sum stage.
    logic vb_reg;
    logic signed [PW-1:0] p_reg [4];
    logic signed [PW-1:0] p_next [4];

    always_comb
    begin
        p_next[0] = sx(prod_reg[0]) + sx(prod_reg[1]) - sx(prod_reg[2]) + sx(prod_reg[3]);
        p_next[1] = -sx(prod_reg[4]) + sx(prod_reg[5]) + sx(prod_reg[6]) + sx(prod_reg[7]);
        p_next[2] = sx(prod_reg[8]) - sx(prod_reg[9]) + sx(prod_reg[10]) + sx(prod_reg[11]);
        p_next[3] = -sx(prod_reg[12]) - sx(prod_reg[13]) - sx(prod_reg[14])
                    + sx(prod_reg[15]);
    end

    // Magnitude stage.
    logic vc_reg;
    logic [MW-1:0] mag_reg [4];
    logic [MW-1:0] mag_next [4];
    logic [3:0] neg_reg;
    logic [3:0] neg_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = p_reg[i][PW-1];
            mag_next[i] = p_reg[i][PW-1] ? MW'(-p_reg[i]) : MW'(p_reg[i]);
        end
    end

    // Scale stage: bring the largest magnitude below 2^31.
    logic vd_reg;
    side_t sd_reg;
    side_t sd_next;
    logic [MW-1:0] orv;
    logic [LW-1:0] len;
    logic [LW-1:0] shift;

    always_comb
    begin
        orv = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
        len = '0;
        for (int j = 0; j < MW; j++)
        begin
            if (orv[j])
            begin
                len = LW'(j + 1);
            end
        end
        shift = (int'(len) > QB) ? LW'(int'(len) - QB) : '0;
        for (int i = 0; i < 4; i++)
        begin
            sd_next.q[i] = QB'(XW'(mag_reg[i]) >> shift);
        end
        sd_next.neg = neg_reg;
        sd_next.zero = (len == '0);
    end

    // Square stage.
    logic ve_reg;
    side_t se_reg;
    logic [2*QB-1:0] sq_reg [4];
    logic [2*QB-1:0] sq_next [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = (2*QB)'(sd_reg.q[i]) * (2*QB)'(sd_reg.q[i]);
        end
    end

    // Square root pipeline, one root bit per stage.
    logic          rv_reg [0:ROOT_STEPS];
    logic [SW-1:0] rs_reg [0:ROOT_STEPS];
    logic [SW-1:0] rr_reg [0:ROOT_STEPS];
    side_t         rside_reg [0:ROOT_STEPS];
    logic [SW-1:0] rs0_next;

    assign rs0_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            p_reg     <= p_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            sd_reg    <= sd_next;
            se_reg    <= sd_reg;
            sq_reg    <= sq_next;
            rs_reg[0] <= rs0_next;
            rr_reg[0] <= '0;
            rside_reg[0] <= se_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++)
        begin : g_root
            localparam logic [SW-1:0] BITV = SW'(1) << (SW - 2 - 2 * k);
            logic [SW-1:0] t;
            logic [SW-1:0] s_next;
            logic [SW-1:0] r_next;

            always_comb
            begin
                t = rr_reg[k] + BITV;
                if (rs_reg[k] >= t)
                begin
                    s_next = rs_reg[k] - t;
                    r_next = (rr_reg[k] >> 1) + BITV;
                end
                else
                begin
                    s_next = rs_reg[k];
                    r_next = rr_reg[k] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rv_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    rv_reg[k+1] <= rv_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rs_reg[k+1]    <= s_next;
                    rr_reg[k+1]    <= r_next;
                    rside_reg[k+1] <= rside_reg[k];
                end
            end
        end
    endgenerate

    // Divider pipeline, one quotient bit per stage for all four components.
    logic          dv_reg [0:F+1];
    logic [DW-1:0] rem_reg [0:F+1][4];
    logic [F:0]    quo_reg [0:F+1][4];
    logic [RW-1:0] dn_reg [0:F+1];
    side_t         dside_reg [0:F+1];
    logic [RW-1:0] n_root;

    assign n_root = rr_reg[ROOT_STEPS][RW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[0][i] <= (DW'(rside_reg[ROOT_STEPS].q[i]) << F)
                                 + DW'(n_root[RW-1:1]);
                quo_reg[0][i] <= '0;
            end
            dn_reg[0]    <= n_root;
            dside_reg[0] <= rside_reg[ROOT_STEPS];
        end
    end

    generate
        for (k = 0; k <= F; k++)
        begin : g_div
            logic [DW-1:0] sub;
            logic [DW-1:0] rem_next [4];
            logic [F:0]    quo_next [4];

            always_comb
            begin
                sub = DW'(dn_reg[k]) << (F - k);
                for (int i = 0; i < 4; i++)
                begin
                    rem_next[i] = rem_reg[k][i];
                    quo_next[i] = quo_reg[k][i];
                    if (rem_reg[k][i] >= sub)
                    begin
                        rem_next[i] = rem_reg[k][i] - sub;
                        quo_next[i][F-k] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_reg[k+1] <= dv_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k+1]   <= rem_next;
                    quo_reg[k+1]   <= quo_next;
                    dn_reg[k+1]    <= dn_reg[k];
                    dside_reg[k+1] <= dside_reg[k];
                end
            end
        end
    endgenerate

    // Saturation, sign and output register.
    localparam logic [CW-1:0] CAPV = CW'(1) << (W - 1);
    localparam logic [CW-1:0] MAXP = CAPV - CW'(1);

    logic signed [W-1:0] r_next [4];
    logic [CW-1:0] mc;

    always_comb
    begin
        mc = '0;
        for (int i = 0; i < 4; i++)
        begin
            mc = (CW'(quo_reg[F+1][i]) > CAPV) ? CAPV : CW'(quo_reg[F+1][i]);
            if (dside_reg[F+1].zero)
            begin
                r_next[i] = '0;
            end
            else if (dside_reg[F+1].neg[i])
            begin
                r_next[i] = W'(-mc);
            end
            else
            begin
                r_next[i] = (mc > MAXP) ? W'(MAXP) : W'(mc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            rv_reg[0]     <= 1'b0;
            dv_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= operands.valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            rv_reg[0]     <= ve_reg;
            dv_reg[0]     <= rv_reg[ROOT_STEPS];
            out_valid_reg <= dv_reg[F+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_next;
            zero_reg <= dside_reg[F+1].zero;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.r_x       = r_reg[0];
    assign result.r_y       = r_reg[1];
    assign result.r_z       = r_reg[2];
    assign result.r_w       = r_reg[3];
    assign result.zero_norm = zero_reg;

endmodule

/* hw/rtl/qmn_checker.sv */
module qmn_checker #(
    parameter int W = 16
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] r_x,
    input logic [W-1:0] r_y,
    input logic [W-1:0] r_z,
    input logic [W-1:0] r_w,
    input logic         zero_norm
);

    // A held result transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_x) && $stable(r_y)
            && $stable(r_z) && $stable(r_w) && $stable(zero_norm))
        else $error("result changed while stalled");

    // The input side never waits when no result is pending.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A zero product gives an all-zero result.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)
        else $error("zero norm with nonzero components");

    // A nonzero product gives a unit quaternion, which has a nonzero component.
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_norm |-> r_x != '0 || r_y != '0 || r_z != '0 || r_w != '0)
        else $error("normalized result is all zero");

endmodule

bind quaternion_multiply_normalize qmn_checker #(.W(COMPONENT_BITS)) u_qmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .r_x       (result.r_x),
    .r_y       (result.r_y),
    .r_z       (result.r_z),
    .r_w       (result.r_w),
    .zero_norm (result.zero_norm)
);
